### hdl/assert_macros.svh
// Assertion macros shared by the RTL files of the position and duty block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset
`define HPU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Next-cycle implication
`define HPU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/hpu_pkg.sv
// Package: widths, register codes and constants of the position and duty block
`default_nettype none
package hpu_pkg;

	localparam int SAMPLE_BITS_DEF     = 10;
	localparam int FLIP_COUNT_BITS_DEF = 8;

	localparam int THR_BITS      = 10;
	localparam int FS_BITS       = 15;
	localparam int TORQUE_BITS   = 16;
	localparam int POS_BITS      = 18;
	localparam int DUTY_BITS     = 8;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 15;

	localparam logic [CFG_IDX_BITS-1:0] REG_FLIP_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FULL_SCALE     = 1'd1;

	localparam logic [THR_BITS-1:0] THR_RESET = 10'd700;
	localparam logic [FS_BITS-1:0]  FS_RESET  = 15'd18300;

	// 255 squared: duty = sqrt(DUTY_SCALE * |torque| / full_scale)
	localparam logic [15:0] DUTY_SCALE = 16'd65025;
	localparam logic [DUTY_BITS-1:0] DUTY_MAX = 8'd255;

	localparam int POS_MAX_INT = 131071;
	localparam int POS_MIN_INT = -131072;

endpackage
`default_nettype wire

### hdl/hpu_if.sv
// Channel interfaces: sample/torque items in, position/duty items out
`default_nettype none
interface hpu_in_if #(
	parameter int SAMPLE_BITS = hpu_pkg::SAMPLE_BITS_DEF
);
	logic                                 valid;
	logic                                 ready;
	logic [SAMPLE_BITS-1:0]               sensor_sample;
	logic signed [hpu_pkg::TORQUE_BITS-1:0] torque_command;

	modport source (output valid, output sensor_sample, output torque_command, input ready);
	modport sink   (input valid, input sensor_sample, input torque_command, output ready);
endinterface

interface hpu_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [hpu_pkg::POS_BITS-1:0] unwrapped_position;
	logic                                motor_direction;
	logic [hpu_pkg::DUTY_BITS-1:0]       pwm_duty;

	modport source (output valid, output unwrapped_position, output motor_direction,
		output pwm_duty, input ready);
	modport sink   (input valid, input unwrapped_position, input motor_direction,
		input pwm_duty, output ready);
endinterface
`default_nettype wire

### hdl/hpu_sub.sv
// Shared subtract and compare unit used by the divider and square-root steps
`default_nettype none
module hpu_sub #(
	parameter int W = 17
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	output logic      [W-1:0] diff,
	output logic              ge
);
	logic [W:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[W-1:0];
	assign ge   = ~full[W];
endmodule
`default_nettype wire

### hdl/hpu_unwrap.sv
// Flip detection, flip count, held offset and saturated position
`default_nettype none
module hpu_unwrap #(
	parameter int SAMPLE_BITS     = hpu_pkg::SAMPLE_BITS_DEF,
	parameter int FLIP_COUNT_BITS = hpu_pkg::FLIP_COUNT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [SAMPLE_BITS-1:0]            sample,
	input  wire logic [hpu_pkg::THR_BITS-1:0]      thr,
	output logic                                   done,
	output logic signed [hpu_pkg::POS_BITS-1:0]    position
);
	localparam int SB = SAMPLE_BITS;
	localparam int FB = FLIP_COUNT_BITS;
	localparam int CW = (SB > hpu_pkg::THR_BITS) ? SB : hpu_pkg::THR_BITS;
	localparam int PW = (FB + SB + 2 > hpu_pkg::POS_BITS + 1) ? FB + SB + 2
		: hpu_pkg::POS_BITS + 1;
	localparam logic signed [FB-1:0] FLIP_MAX = {1'b0, {(FB-1){1'b1}}};
	localparam logic signed [FB-1:0] FLIP_MIN = {1'b1, {(FB-1){1'b0}}};
	localparam logic signed [PW-1:0] POS_MAX_W = PW'(hpu_pkg::POS_MAX_INT);
	localparam logic signed [PW-1:0] POS_MIN_W = PW'(hpu_pkg::POS_MIN_INT);

	logic [SB-1:0]        prev_q, prev2_q, held_q;
	logic signed [FB-1:0] flip_q;
	logic                 jf_q;

	logic [SB-1:0]        cur_off, two_off;
	logic [CW-1:0]        thr_x;
	logic                 two_pos, flip_w, cur_big;

	logic [SB-1:0]        s_s1, s_s2;
	logic                 v_s1, v_s2;
	logic signed [FB+SB:0] prod_s2;
	logic signed [PW-1:0] prod_x, s_x, sum_w;

	assign cur_off = (sample > prev_q)  ? sample - prev_q  : prev_q - sample;
	assign two_off = (sample > prev2_q) ? sample - prev2_q : prev2_q - sample;
	assign two_pos = sample > prev2_q;
	assign thr_x   = CW'(thr);
	assign flip_w  = (CW'(two_off) > thr_x) && !jf_q;
	assign cur_big = CW'(cur_off) > thr_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			prev2_q <= '0;
			held_q  <= '0;
			flip_q  <= '0;
			jf_q    <= 1'b0;
		end else if (start) begin
			prev2_q <= prev_q;
			prev_q  <= sample;
			if (flip_w) begin
				if (two_pos) begin
					if (flip_q != FLIP_MIN)
						flip_q <= flip_q - FB'(1);
				end else begin
					if (flip_q != FLIP_MAX)
						flip_q <= flip_q + FB'(1);
				end
				held_q <= cur_big ? cur_off : two_off;
				jf_q   <= 1'b1;
			end else begin
				jf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			done <= v_s2;
		end
	end

	// stage 1 sees the updated count and offset
	always_ff @(posedge clk) begin
		if (start)
			s_s1 <= sample;
		if (v_s1) begin
			s_s2    <= s_s1;
			prod_s2 <= $signed(flip_q) * $signed({1'b0, held_q});
		end
		if (v_s2) begin
			if (sum_w > POS_MAX_W)
				position <= POS_MAX_W[hpu_pkg::POS_BITS-1:0];
			else if (sum_w < POS_MIN_W)
				position <= POS_MIN_W[hpu_pkg::POS_BITS-1:0];
			else
				position <= sum_w[hpu_pkg::POS_BITS-1:0];
		end
	end

	assign prod_x = PW'(prod_s2);
	assign s_x    = PW'($signed({1'b0, s_s2}));
	assign sum_w  = prod_x + s_x;
endmodule
`default_nettype wire

### hdl/hpu_duty.sv
// Duty sequencer: scale, bit-serial divide and square root on one subtractor
`default_nettype none
`include "assert_macros.svh"
module hpu_duty (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [hpu_pkg::TORQUE_BITS-1:0] torque,
	input  wire logic [hpu_pkg::FS_BITS-1:0]         fs,
	output logic                                     done,
	output logic [hpu_pkg::DUTY_BITS-1:0]            duty_q
);
	localparam int UW = 17;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SAT,
		ST_DIV,
		ST_SQRT,
		ST_DONE
	} state_t;

	state_t        state_q;
	logic [15:0]   mag_q;
	logic [30:0]   num_q;
	logic [14:0]   rem_q;
	logic [15:0]   q_q;
	logic [15:0]   res_q, bit_q;
	logic [3:0]    cnt_q;
	logic          zero_q;

	logic [15:0]   torque_u, mag_w, trial_w;
	logic [31:0]   prod_w;
	logic [UW-1:0] a_w, b_w, diff_w;
	logic          ge_w;

	assign torque_u = torque;
	assign mag_w    = torque_u[15] ? (~torque_u + 16'd1) : torque_u;
	assign prod_w   = {16'd0, hpu_pkg::DUTY_SCALE} * {16'd0, mag_q};
	assign trial_w  = res_q + bit_q;

	always_comb begin
		case (state_q)
			ST_SAT: begin
				a_w = {2'b00, num_q[30:16]};
				b_w = {2'b00, fs};
			end
			ST_DIV: begin
				a_w = {1'b0, rem_q, num_q[cnt_q]};
				b_w = {2'b00, fs};
			end
			ST_SQRT: begin
				a_w = {1'b0, q_q};
				b_w = {1'b0, trial_w};
			end
			default: begin
				a_w = '0;
				b_w = '0;
			end
		endcase
	end

	hpu_sub #(.W(UW)) u_sub (
		.a    (a_w),
		.b    (b_w),
		.diff (diff_w),
		.ge   (ge_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
			duty_q  <= '0;
			mag_q   <= '0;
			num_q   <= '0;
			rem_q   <= '0;
			q_q     <= '0;
			res_q   <= '0;
			bit_q   <= '0;
			cnt_q   <= '0;
			zero_q  <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						mag_q   <= mag_w;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					num_q   <= prod_w[30:0];
					zero_q  <= (mag_q == 16'd0);
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					// zero torque: zero duty; quotient reaches 2^16 (also a zero full scale): full duty
					if (zero_q) begin
						duty_q  <= '0;
						done    <= 1'b1;
						state_q <= ST_DONE;
					end else if (ge_w) begin
						duty_q  <= hpu_pkg::DUTY_MAX;
						done    <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						rem_q   <= num_q[30:16];
						cnt_q   <= 4'd15;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= ge_w ? diff_w[14:0] : a_w[14:0];
					q_q   <= {q_q[14:0], ge_w};
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						res_q   <= '0;
						bit_q   <= 16'h4000;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (ge_w) begin
						q_q   <= diff_w[15:0];
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						duty_q  <= ge_w ? 8'((res_q >> 1) + bit_q) : 8'(res_q >> 1);
						done    <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`HPU_ASSERT(a_sqrt_onehot, (state_q == ST_SQRT) |-> $onehot(bit_q), "sqrt bit not one-hot")
	`HPU_ASSERT(a_rem_below_fs, (state_q == ST_DIV) |-> (rem_q < fs), "remainder not below full scale")
	`HPU_ASSERT(a_zero_duty, (state_q == ST_DONE && zero_q) |-> (duty_q == '0), "zero torque gave duty")
endmodule
`default_nettype wire

### hdl/haptic_position_unwrap_torque_pwm_core.sv
// Top level: handshakes, configuration registers, unwrap and duty units
//
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+----------------------------------------------
//  in_ch    | in  | valid/ready | sensor_sample, torque_command
//  out_ch   | out | valid/ready | unwrapped_position, motor_direction, pwm_duty
//  cfg      | in  | cfg_we      | cfg_index, cfg_wdata (flip threshold, full scale)
//
// The duty sequencer sets how long an item takes, from acceptance to result and to the next
// acceptance: 16 divide steps and 8 square-root steps on one shared subtractor. Zero torque
// or a saturated quotient gives the result without the divide and square-root steps.
// in_ch.ready is low while an item is in work; a finished result waits in the
// output register, so the next item is taken while out_ch stalls.
// Reset clears history, flip count, offset and control; registers reset to 700/18300.
`default_nettype none
`include "assert_macros.svh"
module haptic_position_unwrap_torque_pwm_core #(
	parameter int SAMPLE_BITS     = hpu_pkg::SAMPLE_BITS_DEF,
	parameter int FLIP_COUNT_BITS = hpu_pkg::FLIP_COUNT_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	hpu_in_if.sink                                  in_ch,
	hpu_out_if.source                               out_ch,
	input  wire logic                               cfg_we,
	input  wire logic [hpu_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [hpu_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
	logic [hpu_pkg::THR_BITS-1:0] thr_q;
	logic [hpu_pkg::FS_BITS-1:0]  fs_q;

	logic busy_q, duty_f_q, pos_f_q, dir_q, out_valid_q;
	logic accept, load;
	logic duty_done, pos_done;
	logic [hpu_pkg::DUTY_BITS-1:0]        duty_w;
	logic signed [hpu_pkg::POS_BITS-1:0]  pos_w;
	logic [hpu_pkg::DUTY_BITS-1:0]        duty_q;
	logic signed [hpu_pkg::POS_BITS-1:0]  pos_q;
	logic                                 dir_out_q;

	assign in_ch.ready = ~busy_q;
	assign accept      = in_ch.valid & ~busy_q;
	assign load        = busy_q & (duty_f_q | duty_done) & (pos_f_q | pos_done)
		& (~out_valid_q | out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= hpu_pkg::THR_RESET;
			fs_q  <= hpu_pkg::FS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				hpu_pkg::REG_FLIP_THRESHOLD: thr_q <= cfg_wdata[hpu_pkg::THR_BITS-1:0];
				hpu_pkg::REG_FULL_SCALE:     fs_q  <= cfg_wdata[hpu_pkg::FS_BITS-1:0];
				default: ;
			endcase
		end
	end

	hpu_unwrap #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.FLIP_COUNT_BITS (FLIP_COUNT_BITS)
	) u_unwrap (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.sample   (in_ch.sensor_sample),
		.thr      (thr_q),
		.done     (pos_done),
		.position (pos_w)
	);

	hpu_duty u_duty (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.torque (in_ch.torque_command),
		.fs     (fs_q),
		.done   (duty_done),
		.duty_q (duty_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			duty_f_q    <= 1'b0;
			pos_f_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				busy_q <= 1'b1;
			else if (load)
				busy_q <= 1'b0;
			// done pulses are held until the result moves to the output
			if (load) begin
				duty_f_q <= 1'b0;
				pos_f_q  <= 1'b0;
			end else begin
				if (duty_done)
					duty_f_q <= 1'b1;
				if (pos_done)
					pos_f_q <= 1'b1;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			dir_q <= ~in_ch.torque_command[hpu_pkg::TORQUE_BITS-1]
				& (in_ch.torque_command != '0);
		if (load) begin
			pos_q     <= pos_w;
			duty_q    <= duty_w;
			dir_out_q <= dir_q;
		end
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.unwrapped_position = pos_q;
	assign out_ch.motor_direction    = dir_out_q;
	assign out_ch.pwm_duty           = duty_q;

	`HPU_ASSERT(a_done_while_busy, (duty_done || pos_done) |-> busy_q, "unit done with no item")
	`HPU_ASSERT_NEXT(a_flags_clear, accept, !duty_f_q && !pos_f_q, "stale done flag on new item")
endmodule
`default_nettype wire
